// ===== design/ssst_pkg.sv =====
`default_nettype none

package ssst_pkg;

    // stream payload widths (whole bytes) and the result word width
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;
    localparam int RES_W      = 50;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_ENTER  = 2'd2,
        FUNC_EXIT   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // fields of a matched entry
    typedef struct packed {
        logic [19:0] line;
        logic [7:0]  scope;
        logic [3:0]  vtype;
    } t_found;

    // compare flags for the entry on the read port
    typedef struct packed {
        logic name_eq;
        logic level_eq;
    } t_cmp;

    // result word, first field in the high bits
    typedef struct packed {
        logic [6:0]  entry_count;
        logic [7:0]  level_now;
        t_status     status;
        logic [19:0] found_line;
        logic [7:0]  found_scope;
        logic [3:0]  found_type;
        logic        found;
    } t_result;

    // zero every byte from the first zero byte on
    function automatic logic [63:0] end_at_nul(input logic [63:0] v);
        logic [63:0] r;
        logic        live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (v[8*i +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/scoped_symbol_stack_table.sv =====
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: sym_name, var_type, line_number
// m_*       out  m_tvalid/m_tready  tdata: found, found_type, found_scope, found_line,
//                                          status, level_now, entry_count
//
// Add and enter go from accept (memory write for add) to the result register,
// then to the output register. Lookup and exit read the entry memory newest to
// oldest, one entry per cycle on its single read port. A new request is taken as
// soon as the sequencer is idle, even while the previous result still sits in the
// output register.
// Reset (synchronous, active low) empties the stack and zeroes the scope level;
// the entry memory needs no clearing pass since only entries below the top are read.

module scoped_symbol_stack_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int NAME_CHARS  = 8,
    parameter int MAX_LEVEL   = 255
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [63:0] sym_name, [67:64] var_type, [87:68] line_number
    input  wire logic [ssst_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] func
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] found, [4:1] found_type, [12:5] found_scope, [32:13] found_line,
    // [34:33] status, [42:35] level_now, [49:43] entry_count, [55:50] zero
    output logic [ssst_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import ssst_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int TOP_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
    localparam int NAME_W = 8 * NAME_CHARS;
    localparam int EW     = NAME_W + 4 + LVL_W + 20;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_func            r_op, n_op;
    logic [63:0]      r_key, n_key;
    logic [AW-1:0]    r_idx, n_idx;
    logic [TOP_W-1:0] r_top, n_top;
    logic [LVL_W-1:0] r_level, n_level;
    t_result          r_res, n_res;
    logic             r_out_valid;
    t_result          r_out;

    // request decode
    logic        s_acc;
    t_func       in_op;
    logic [63:0] in_name;
    logic [3:0]  in_type;
    logic [19:0] in_line;

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_op    = t_func'(s_tuser);
    assign in_name  = end_at_nul(s_tdata[63:0]);
    assign in_type  = s_tdata[67:64];
    assign in_line  = s_tdata[87:68];

    // entry memory: one write port for pushes, one read port for scans
    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;

    assign wr_data = {in_name[NAME_W-1:0], in_type, r_level, in_line};

    ssst_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_top[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (n_idx),
        .o_rdata (rd_data)
    );

    t_cmp   cmp;
    t_found fnd;

    ssst_match #(
        .NAME_W (NAME_W),
        .LVL_W  (LVL_W)
    ) u_match (
        .i_entry (rd_data),
        .i_key   (r_key),
        .i_level (r_level),
        .o_cmp   (cmp),
        .o_found (fnd)
    );

    logic    out_free;
    logic    fin;
    logic    hit;
    logic    exit_end;
    t_status res_status;

    assign out_free = !r_out_valid || m_tready;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_idx      = r_idx;
        n_top      = r_top;
        n_level    = r_level;
        n_res      = r_res;
        wr_en      = 1'b0;
        fin        = 1'b0;
        hit        = 1'b0;
        exit_end   = 1'b0;
        res_status = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op  = in_op;
                    n_key = in_name;
                    // first read goes out now: newest entry
                    n_idx = AW'(r_top - TOP_W'(1));
                    unique case (in_op)
                        FUNC_ADD: begin
                            if (r_top == TOP_W'(TABLE_DEPTH)) begin
                                res_status = ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                n_top = r_top + TOP_W'(1);
                            end
                            fin = 1'b1;
                        end
                        FUNC_LOOKUP: begin
                            if (r_top == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_ENTER: begin
                            if (r_level == LVL_W'(MAX_LEVEL)) begin
                                res_status = ST_OVERFLOW;
                            end else begin
                                n_level = r_level + LVL_W'(1);
                            end
                            fin = 1'b1;
                        end
                        FUNC_EXIT: begin
                            if (r_top == '0) begin
                                fin      = 1'b1;
                                exit_end = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // rd_data holds entry r_idx
                if (r_op == FUNC_LOOKUP) begin
                    if (cmp.name_eq) begin
                        fin = 1'b1;
                        hit = 1'b1;
                    end else if (r_idx == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    if (cmp.level_eq) begin
                        n_top = TOP_W'(r_idx);
                        if (r_idx == '0) begin
                            fin      = 1'b1;
                            exit_end = 1'b1;
                        end else begin
                            n_idx = r_idx - AW'(1);
                        end
                    end else begin
                        fin      = 1'b1;
                        exit_end = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // leaving a scope after its entries are popped
        if (exit_end) begin
            if (r_level == '0) begin
                res_status = ST_UNDERFLOW;
            end else begin
                n_level = r_level - LVL_W'(1);
            end
        end

        if (fin) begin
            n_state           = S_FIN;
            n_res.found       = hit;
            n_res.found_type  = hit ? fnd.vtype : 4'd0;
            n_res.found_scope = hit ? fnd.scope : 8'd0;
            n_res.found_line  = hit ? fnd.line : 20'd0;
            n_res.status      = res_status;
            n_res.level_now   = 8'(n_level);
            n_res.entry_count = 7'(n_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_level <= n_level;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_idx <= n_idx;
        r_res <= n_res;
        if (r_state == S_FIN && out_free) begin
            r_out <= r_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(OUT_DATA_W - RES_W)'(0), r_out};

    // checks
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(TABLE_DEPTH))
        else $error("stack top beyond table depth");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(MAX_LEVEL))
        else $error("scope level beyond maximum");

    a_scan_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> TOP_W'(r_idx) < r_top)
        else $error("scan index not below stack top");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out.status == ST_FULL) |-> r_out.entry_count == 7'(TABLE_DEPTH))
        else $error("full status with room left");

endmodule

`default_nettype wire

// ===== design/ssst_ram.sv =====
`default_nettype none

module ssst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/ssst_match.sv =====
`default_nettype none

module ssst_match #(
    parameter int NAME_W = 64,
    parameter int LVL_W  = 8
) (
    input  wire logic [NAME_W+LVL_W+23:0] i_entry,
    input  wire logic [63:0]              i_key,
    input  wire logic [LVL_W-1:0]         i_level,
    output ssst_pkg::t_cmp                o_cmp,
    output ssst_pkg::t_found              o_found
);
    import ssst_pkg::*;

    // entry layout: {name, type, level, line}
    logic [NAME_W-1:0] e_name;
    logic [3:0]        e_type;
    logic [LVL_W-1:0]  e_level;
    logic [19:0]       e_line;

    assign e_line  = i_entry[19:0];
    assign e_level = i_entry[20 +: LVL_W];
    assign e_type  = i_entry[20+LVL_W +: 4];
    assign e_name  = i_entry[24+LVL_W +: NAME_W];

    // stored name is zero padded, so a longer key never matches
    assign o_cmp.name_eq  = (i_key == 64'(e_name));
    assign o_cmp.level_eq = (e_level == i_level);

    assign o_found.line  = e_line;
    assign o_found.scope = 8'(e_level);
    assign o_found.vtype = e_type;

endmodule

`default_nettype wire

// ===== verif/scoped_symbol_stack_table_tb.sv =====
module scoped_symbol_stack_table_tb;
    import ssst_pkg::*;

    localparam int DEPTH     = 64;          // entries the table holds
    localparam int TOP_LEVEL = 255;         // highest scope level
    localparam int N_RANDOM  = 1050;        // rough size of the random part
    localparam int POOL_N    = 12;          // names reused so lookups hit
    localparam int STALL_MAX = 4000;        // cycles without any handshake
    localparam int DRAIN_CYC = DEPTH + 10;  // longest scan plus margin

    typedef struct packed {
        t_func       op;
        logic [63:0] name;
        logic [3:0]  vtype;
        logic [19:0] line;
    } t_request;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // sym_name, var_type, line_number
    logic [1:0]            s_tuser  = '0;   // func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // found .. entry_count, zero pad

    scoped_symbol_stack_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // requests waiting to be driven, results waiting to come back
    t_request cmd_q[$];
    t_result  result_q[$];

    // bookkeeping
    int   cyc        = 0;
    logic rst_seen   = 1'b0;   // reset as seen at the last rising edge
    logic req_taken  = 1'b0;   // request handshake at the last rising edge
    int   n_total    = 0;
    int   n_accepted = 0;
    int   n_bad      = 0;
    int   n_stray    = 0;
    int   stall      = 0;

    // coverage counters kept by the predictor
    int n_op[4];
    int n_hit      = 0;
    int n_full     = 0;
    int n_over     = 0;
    int n_under    = 0;
    int peak_depth = 0;
    int peak_level = 0;

    // ---------------------------------------------------------------
    // Predictor: private copy of the symbol stack
    // ---------------------------------------------------------------
    logic [63:0] sym_names  [DEPTH];
    logic [3:0]  sym_types  [DEPTH];
    logic [7:0]  sym_levels [DEPTH];
    logic [19:0] sym_lines  [DEPTH];
    int          stack_depth = 0;
    int          scope_now   = 0;

    // a name ends at its first zero byte; anything past it is dropped
    function automatic logic [63:0] trim_name(input logic [63:0] v);
        logic [63:0] r;
        logic        ended;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (v[8*i +: 8] == 8'd0)
                ended = 1'b1;
            if (!ended)
                r[8*i +: 8] = v[8*i +: 8];
        end
        return r;
    endfunction

    task automatic table_step(input t_request rq, output t_result r);
        logic [63:0] nm;
        r  = '0;
        nm = trim_name(rq.name);
        n_op[rq.op]++;
        case (rq.op)
            FUNC_ADD: begin
                if (stack_depth >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    sym_names[stack_depth]  = nm;
                    sym_types[stack_depth]  = rq.vtype;
                    sym_levels[stack_depth] = 8'(scope_now);
                    sym_lines[stack_depth]  = rq.line;
                    stack_depth++;
                end
            end
            FUNC_LOOKUP: begin
                // newest entry wins, so shadowed names resolve to the inner scope
                for (int k = stack_depth - 1; k >= 0 && !r.found; k--) begin
                    if (sym_names[k] == nm) begin
                        r.found       = 1'b1;
                        r.found_type  = sym_types[k];
                        r.found_scope = sym_levels[k];
                        r.found_line  = sym_lines[k];
                    end
                end
                if (r.found)
                    n_hit++;
            end
            FUNC_ENTER: begin
                if (scope_now >= TOP_LEVEL) begin
                    r.status = ST_OVERFLOW;
                    n_over++;
                end else begin
                    scope_now++;
                end
            end
            default: begin
                // pop the current scope; at level 0 this still drops level-0 entries
                while (stack_depth > 0 && sym_levels[stack_depth-1] == 8'(scope_now))
                    stack_depth--;
                if (scope_now == 0) begin
                    r.status = ST_UNDERFLOW;
                    n_under++;
                end else begin
                    scope_now--;
                end
            end
        endcase
        r.level_now   = 8'(scope_now);
        r.entry_count = 7'(stack_depth);
        if (stack_depth > peak_depth)
            peak_depth = stack_depth;
        if (scope_now > peak_level)
            peak_level = scope_now;
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    logic [63:0] name_pool [POOL_N];
    int          pool_len  [POOL_N];
    int          gen_level = 0;   // scope level the queued requests lead to

    function automatic logic [63:0] make_name(input int len);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
            v[8*i +: 8] = 8'($urandom_range(1, 255));
        return v;
    endfunction

    // mostly pool names (sometimes with junk past the terminator), some fresh
    function automatic logic [63:0] any_name();
        logic [63:0] v;
        int          pick;
        int          p;
        pick = $urandom_range(99);
        if (pick < 60) begin
            p = $urandom_range(POOL_N - 1);
            v = name_pool[p];
            if (pool_len[p] < 8 && $urandom_range(2) == 0)
                for (int i = pool_len[p] + 1; i < 8; i++)
                    v[8*i +: 8] = 8'($urandom);
        end else if (pick < 85) begin
            v = make_name($urandom_range(1, 8));
        end else begin
            v = {$urandom, $urandom};
        end
        return v;
    endfunction

    task automatic put_req(input t_func op, input logic [63:0] nm,
                           input logic [3:0] ty, input logic [19:0] ln);
        t_request rq;
        rq.op    = op;
        rq.name  = nm;
        rq.vtype = ty;
        rq.line  = ln;
        cmd_q.push_back(rq);
        if (op == FUNC_ENTER && gen_level < TOP_LEVEL)
            gen_level++;
        if (op == FUNC_EXIT && gen_level > 0)
            gen_level--;
    endtask

    task automatic put_rand(input t_func op);
        put_req(op, any_name(), 4'($urandom), 20'($urandom));
    endtask

    // free mix of all four operations
    task automatic mix_ops(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 35)
                put_rand(FUNC_ADD);
            else if (r < 70)
                put_rand(FUNC_LOOKUP);
            else if (r < 85)
                put_rand(FUNC_ENTER);
            else
                put_rand(FUNC_EXIT);
        end
    endtask

    // one exit per open level plus one at level 0 empties the stack
    task automatic unwind_all();
        int levels;
        levels = gen_level;
        for (int i = 0; i <= levels; i++) begin
            put_rand(FUNC_EXIT);
            if ($urandom_range(9) == 0)
                put_rand(FUNC_LOOKUP);
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: inputs move on the falling edge
    // ---------------------------------------------------------------
    wire calm = (cyc >= 3000 && cyc < 8000);   // long stretch with no idling

    always @(negedge i_clk) begin : drive
        t_request rq;
        if (!rst_seen) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || req_taken) begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
                    rq = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= rq.op;
                    s_tdata  <= {rq.line, rq.vtype, rq.name};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || $urandom_range(99) >= 8;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: both handshakes sampled on the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_request rq;
        t_result  want;
        t_result  got;
        cyc       <= cyc + 1;
        rst_seen  <= i_rst_n;
        req_taken <= s_tvalid && s_tready;

        if (rst_seen && s_tvalid && s_tready) begin
            rq.op    = t_func'(s_tuser);
            rq.name  = s_tdata[63:0];
            rq.vtype = s_tdata[67:64];
            rq.line  = s_tdata[87:68];
            table_step(rq, want);
            result_q.push_back(want);
            n_accepted++;
        end

        if (rst_seen && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[RES_W-1:0]);
            if (result_q.size() == 0) begin
                n_stray++;
                if (n_bad + n_stray <= 10)
                    $display("unexpected result %h at cycle %0d", m_tdata, cyc);
            end else begin
                want = result_q.pop_front();
                if (got.found !== want.found || got.found_type !== want.found_type ||
                    got.found_scope !== want.found_scope ||
                    got.found_line !== want.found_line || got.status !== want.status ||
                    got.level_now !== want.level_now ||
                    got.entry_count !== want.entry_count ||
                    m_tdata[OUT_DATA_W-1:RES_W] !== '0) begin
                    n_bad++;
                    if (n_bad + n_stray <= 10) begin
                        $display("mismatch at cycle %0d", cyc);
                        $display("  exp found=%0d type=%0d scope=%0d line=%0d st=%0d lvl=%0d cnt=%0d",
                                 want.found, want.found_type, want.found_scope,
                                 want.found_line, want.status, want.level_now,
                                 want.entry_count);
                        $display("  got found=%0d type=%0d scope=%0d line=%0d st=%0d lvl=%0d cnt=%0d pad=%h",
                                 got.found, got.found_type, got.found_scope,
                                 got.found_line, got.status, got.level_now,
                                 got.entry_count, m_tdata[OUT_DATA_W-1:RES_W]);
                    end
                end
            end
        end
    end

    // watchdog: any handshake resets the count
    always @(posedge i_clk) begin
        if (rst_seen) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall <= 0;
            end else if (stall >= STALL_MAX) begin
                $display("watchdog: no progress for %0d cycles", STALL_MAX);
                $display("Regression FAIL");
                $finish;
            end else begin
                stall <= stall + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        logic [63:0] bottom_name;
        int          base;

        for (int i = 0; i < 4; i++)
            n_op[i] = 0;
        for (int i = 0; i < POOL_N; i++) begin
            pool_len[i]  = (i == 0) ? 8 : $urandom_range(1, 8);
            name_pool[i] = make_name(pool_len[i]);
        end

        // directed: extremes, shadowing, junk past terminator, underflow pops
        put_req(FUNC_EXIT,   '0, 4'h0, 20'h0);                       // empty, level 0
        put_req(FUNC_LOOKUP, '1, 4'h0, 20'h0);                       // miss on empty
        put_req(FUNC_ADD,    '0, 4'h0, 20'h00000);                   // empty name
        put_req(FUNC_ADD,    '1, 4'hF, 20'hFFFFF);                   // all-ones name
        put_req(FUNC_LOOKUP, '1, 4'h0, 20'h0);
        put_req(FUNC_LOOKUP, 64'hA5C3_0F77_1E2D_3C00, 4'h0, 20'h0);   // trims to empty
        put_req(FUNC_ENTER,  '0, 4'h0, 20'h0);
        put_req(FUNC_ADD,    64'hDEAD_BEEF_0063_6261, 4'h9, 20'h12345); // "abc" + junk
        put_req(FUNC_ADD,    '1, 4'h3, 20'h00001);                   // shadows outer
        put_req(FUNC_LOOKUP, '1, 4'h0, 20'h0);
        put_req(FUNC_LOOKUP, 64'h0000_0000_0063_6261, 4'h0, 20'h0);
        put_req(FUNC_LOOKUP, 64'h0000_0000_0000_6261, 4'h0, 20'h0);   // prefix, miss
        put_req(FUNC_EXIT,   '0, 4'h0, 20'h0);
        put_req(FUNC_LOOKUP, '1, 4'h0, 20'h0);                       // outer again
        put_req(FUNC_LOOKUP, 64'h0000_0000_0063_6261, 4'h0, 20'h0);   // popped
        put_req(FUNC_EXIT,   '0, 4'h0, 20'h0);                       // pops level 0
        put_req(FUNC_LOOKUP, '0, 4'h0, 20'h0);
        base = cmd_q.size();

        // free mix of scope changes, adds and lookups with random content
        mix_ops(250);

        // fill the table to the brim, scan it deep, then unwind
        unwind_all();
        bottom_name = any_name();
        put_req(FUNC_ADD, bottom_name, 4'($urandom), 20'($urandom));
        for (int i = 1; i < DEPTH; i++) begin
            if ($urandom_range(9) == 0)
                put_rand(FUNC_ENTER);
            put_rand(FUNC_ADD);
        end
        for (int i = 0; i < 3; i++)
            put_rand(FUNC_ADD);                                      // table full
        put_req(FUNC_LOOKUP, bottom_name, 4'h0, 20'h0);
        put_req(FUNC_LOOKUP, {$urandom, $urandom}, 4'h0, 20'h0);     // likely full-scan miss
        for (int i = 0; i < 4; i++)
            put_rand(FUNC_LOOKUP);
        unwind_all();

        // climb to the top level with scattered adds, overflow, then all the way down
        while (gen_level < TOP_LEVEL) begin
            put_rand(FUNC_ENTER);
            if ($urandom_range(9) == 0)
                put_rand(FUNC_ADD);
            if ($urandom_range(19) == 0)
                put_rand(FUNC_LOOKUP);
        end
        for (int i = 0; i < 3; i++)
            put_rand(FUNC_ENTER);
        for (int i = 0; i < 3; i++)
            put_rand(FUNC_LOOKUP);
        unwind_all();
        put_rand(FUNC_EXIT);

        // free mix for the rest
        if (cmd_q.size() - base < N_RANDOM)
            mix_ops(N_RANDOM - (cmd_q.size() - base));
        n_total = cmd_q.size();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent and answered, then let the pipe settle
        while (n_accepted < n_total || result_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);

        $display("%0d requests: %0d add, %0d lookup (%0d hits), %0d enter, %0d exit",
                 n_accepted, n_op[FUNC_ADD], n_op[FUNC_LOOKUP], n_hit,
                 n_op[FUNC_ENTER], n_op[FUNC_EXIT]);
        $display("table full %0d, overflow %0d, underflow %0d; deepest %0d, top level %0d",
                 n_full, n_over, n_under, peak_depth, peak_level);
        if (n_bad == 0 && n_stray == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d unexpected results", n_bad, n_stray);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ssst_pkg.sv
design/ssst_ram.sv
design/ssst_match.sv
design/scoped_symbol_stack_table.sv
verif/scoped_symbol_stack_table_tb.sv
